/* src/seek_pkg.sv */
package seek_pkg;

    // default disk geometry limits
    localparam int MAX_TRACKS_DEF  = 32;
    localparam int MAX_SECTORS_DEF = 64;

    // payload field widths
    localparam int SECTOR_ID_W = 11;
    localparam int TIME_W      = 23;

    // configuration register widths
    localparam int NUM_TRACKS_W  = 6;
    localparam int NUM_SECTORS_W = 7;
    localparam int INC_W         = 6;
    localparam int DELAY_W       = 16;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_NUM_TRACKS       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_NUM_SECTORS      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SECTOR_INCREMENT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TRACK_DELAY      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SECTOR_DELAY     = 3'd4;

    // register reset values
    localparam logic [NUM_TRACKS_W-1:0]  NUM_TRACKS_RST       = 6'd32;
    localparam logic [NUM_SECTORS_W-1:0] NUM_SECTORS_RST      = 7'd64;
    localparam logic [INC_W-1:0]         SECTOR_INCREMENT_RST = 6'd1;
    localparam logic [DELAY_W-1:0]       TRACK_DELAY_RST      = 16'd256;
    localparam logic [DELAY_W-1:0]       SECTOR_DELAY_RST     = 16'd16;

    // which value the shared divider works on
    typedef enum logic [1:0] {
        DIV_SEL_HEAD,
        DIV_SEL_INC,
        DIV_SEL_TGT
    } seek_div_sel_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_HEAD,
        ST_WAIT_HEAD,
        ST_DIV_INC,
        ST_WAIT_INC,
        ST_DIV_TGT,
        ST_WAIT_TGT,
        ST_CHECK,
        ST_STEP,
        ST_SECTOR_WAIT,
        ST_EMIT
    } seek_state_t;

    // controller to datapath
    typedef struct packed {
        logic          load;
        logic          div_start;
        seek_div_sel_t div_sel;
        logic          step;
        logic          sector_wait;
        logic          emit;
    } seek_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic bad;
        logic at_target;
        logic more_steps;
        logic last;
        logic out_free;
    } seek_status_t;

endpackage

/* src/seek_in_if.sv */
interface seek_in_if;
    import seek_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SECTOR_ID_W-1:0] target_sector;

    modport source (output valid, output target_sector, input ready);
    modport sink (input valid, input target_sector, output ready);
endinterface

/* src/seek_out_if.sv */
interface seek_out_if;
    import seek_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SECTOR_ID_W-1:0] visited_sector;
    logic [TIME_W-1:0]      elapsed_time;
    logic                   bad_request;
    logic                   last_of_run;

    modport source (
        output valid, output visited_sector, output elapsed_time,
        output bad_request, output last_of_run, input ready
    );
    modport sink (
        input valid, input visited_sector, input elapsed_time,
        input bad_request, input last_of_run, output ready
    );
endinterface

/* src/seek_div.sv */
module seek_div #(
    parameter int DVD_W = 11,
    parameter int DVS_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] diff;
    logic           ge;

    // one restoring step: shift in the next dividend bit and try to subtract
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[DVD_W-1]};
        diff    = shifted - {1'b0, divisor};
        ge      = shifted >= {1'b0, divisor};
    end

    // iteration control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            dvd_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            quo_next = {quo_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

/* src/seek_regs.sv */
module seek_regs #(
    parameter  int MAX_TRACKS  = seek_pkg::MAX_TRACKS_DEF,
    parameter  int MAX_SECTORS = seek_pkg::MAX_SECTORS_DEF,
    localparam int NT_W        = $clog2(MAX_TRACKS + 1),
    localparam int NS_W        = $clog2(MAX_SECTORS + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [seek_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [seek_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [seek_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [NT_W-1:0]                   nt,
    output logic [NS_W-1:0]                   ns,
    output logic [seek_pkg::INC_W-1:0]        sector_increment,
    output logic [seek_pkg::DELAY_W-1:0]      step_delay,
    output logic [seek_pkg::DELAY_W-1:0]      sector_delay
);
    import seek_pkg::*;

    logic [NUM_TRACKS_W-1:0]  num_tracks_reg;
    logic [NUM_SECTORS_W-1:0] num_sectors_reg;
    logic [INC_W-1:0]         sector_increment_reg;
    logic [DELAY_W-1:0]       step_delay_reg;
    logic [DELAY_W-1:0]       sector_delay_reg;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[APB_ADDR_W-1:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_tracks_reg       <= NUM_TRACKS_RST;
            num_sectors_reg      <= NUM_SECTORS_RST;
            sector_increment_reg <= SECTOR_INCREMENT_RST;
            step_delay_reg       <= TRACK_DELAY_RST;
            sector_delay_reg     <= SECTOR_DELAY_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_NUM_TRACKS:       num_tracks_reg       <= pwdata[NUM_TRACKS_W-1:0];
                REG_NUM_SECTORS:      num_sectors_reg      <= pwdata[NUM_SECTORS_W-1:0];
                REG_SECTOR_INCREMENT: sector_increment_reg <= pwdata[INC_W-1:0];
                REG_TRACK_DELAY:      step_delay_reg       <= pwdata[DELAY_W-1:0];
                REG_SECTOR_DELAY:     sector_delay_reg     <= pwdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // readback
    always_comb
    begin
        case (idx)
            REG_NUM_TRACKS:       prdata = APB_DATA_W'(num_tracks_reg);
            REG_NUM_SECTORS:      prdata = APB_DATA_W'(num_sectors_reg);
            REG_SECTOR_INCREMENT: prdata = APB_DATA_W'(sector_increment_reg);
            REG_TRACK_DELAY:      prdata = APB_DATA_W'(step_delay_reg);
            REG_SECTOR_DELAY:     prdata = APB_DATA_W'(sector_delay_reg);
            default:              prdata = '0;
        endcase
    end

    // effective geometry: zero acts as one, oversize acts as the limit
    always_comb
    begin
        if (num_tracks_reg == '0)
            nt = NT_W'(1);
        else if (num_tracks_reg > NUM_TRACKS_W'(MAX_TRACKS))
            nt = NT_W'(MAX_TRACKS);
        else
            nt = num_tracks_reg[NT_W-1:0];

        if (num_sectors_reg == '0)
            ns = NS_W'(1);
        else if (num_sectors_reg > NUM_SECTORS_W'(MAX_SECTORS))
            ns = NS_W'(MAX_SECTORS);
        else
            ns = num_sectors_reg[NS_W-1:0];
    end

    assign sector_increment = sector_increment_reg;
    assign step_delay       = step_delay_reg;
    assign sector_delay     = sector_delay_reg;
endmodule

/* src/seek_dp.sv */
module seek_dp #(
    parameter  int MAX_TRACKS  = seek_pkg::MAX_TRACKS_DEF,
    parameter  int MAX_SECTORS = seek_pkg::MAX_SECTORS_DEF,
    localparam int NT_W        = $clog2(MAX_TRACKS + 1),
    localparam int NS_W        = $clog2(MAX_SECTORS + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  seek_pkg::seek_cmd_t                cmd,
    output seek_pkg::seek_status_t             status,
    input  logic [seek_pkg::SECTOR_ID_W-1:0]   target_sector,
    input  logic [NT_W-1:0]                    nt,
    input  logic [NS_W-1:0]                    ns,
    input  logic [seek_pkg::INC_W-1:0]         sector_increment,
    input  logic [seek_pkg::DELAY_W-1:0]       step_delay,
    input  logic [seek_pkg::DELAY_W-1:0]       sector_delay,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [seek_pkg::SECTOR_ID_W-1:0]   visited_sector,
    output logic [seek_pkg::TIME_W-1:0]        elapsed_time,
    output logic                               bad_request,
    output logic                               last_of_run
);
    import seek_pkg::*;

    localparam int TRACK_W  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int SECTOR_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int LIMIT    = 2 * MAX_TRACKS - 2;
    localparam int CNT_W    = $clog2(LIMIT + 1);
    localparam int FULL_W   = SECTOR_ID_W + TRACK_W + NS_W;
    localparam int PROD_W   = NS_W + DELAY_W;

    // head state
    logic [TRACK_W-1:0]  head_track_reg, head_track_next;
    logic [SECTOR_W-1:0] head_sector_reg, head_sector_next;
    logic                moving_up_reg, moving_up_next;

    // request state
    logic [SECTOR_ID_W-1:0] tgt_reg, tgt_next;
    logic [SECTOR_ID_W-1:0] t_track_reg, t_track_next;
    logic [SECTOR_W-1:0]    t_sector_reg, t_sector_next;
    logic [SECTOR_W-1:0]    inc_reg, inc_next;
    logic [TIME_W-1:0]      time_reg, time_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [SECTOR_ID_W-1:0] out_id_reg, out_id_next;
    logic [TIME_W-1:0]      out_time_reg, out_time_next;
    logic                   out_bad_reg, out_bad_next;
    logic                   out_last_reg, out_last_next;

    // divider
    logic                   div_done;
    logic [SECTOR_ID_W-1:0] div_dividend;
    logic [SECTOR_ID_W-1:0] div_quo;
    logic [NS_W-1:0]        div_rem;

    // combinational helpers
    logic [NT_W-1:0]     nt_m1;
    logic [NS_W:0]       sec_sum;
    logic [SECTOR_W-1:0] sec_stepped;
    logic [NS_W-1:0]     sec_gap;
    logic [PROD_W-1:0]   wait_prod;
    logic [FULL_W-1:0]   id_full;
    logic                at_top;
    logic                track_hit;
    logic                sector_hit;
    logic                bad;
    logic                more_steps;

    // divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            DIV_SEL_HEAD: div_dividend = SECTOR_ID_W'(head_sector_reg);
            DIV_SEL_INC:  div_dividend = SECTOR_ID_W'(sector_increment);
            DIV_SEL_TGT:  div_dividend = tgt_reg;
            default:      div_dividend = tgt_reg;
        endcase
    end

    seek_div #(
        .DVD_W (SECTOR_ID_W),
        .DVS_W (NS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (ns),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // compares, sector arithmetic and the linear id
    always_comb
    begin
        nt_m1       = nt - 1'b1;
        at_top      = NT_W'(head_track_reg) == nt_m1;
        track_hit   = t_track_reg == SECTOR_ID_W'(head_track_reg);
        sector_hit  = t_sector_reg == head_sector_reg;
        bad         = t_track_reg >= SECTOR_ID_W'(nt);
        more_steps  = !track_hit && (cnt_reg < CNT_W'(LIMIT));
        sec_sum     = (NS_W + 1)'(head_sector_reg) + (NS_W + 1)'(inc_reg);
        if (sec_sum >= (NS_W + 1)'(ns))
            sec_sum = sec_sum - (NS_W + 1)'(ns);
        sec_stepped = sec_sum[SECTOR_W-1:0];
        if (t_sector_reg >= head_sector_reg)
            sec_gap = NS_W'(t_sector_reg) - NS_W'(head_sector_reg);
        else
            sec_gap = NS_W'(t_sector_reg) + ns - NS_W'(head_sector_reg);
        wait_prod   = PROD_W'(sec_gap) * PROD_W'(sector_delay);
        id_full     = FULL_W'(head_track_reg) * FULL_W'(ns) + FULL_W'(head_sector_reg);
    end

    // next-state logic
    always_comb
    begin
        head_track_next  = head_track_reg;
        head_sector_next = head_sector_reg;
        moving_up_next   = moving_up_reg;
        tgt_next         = tgt_reg;
        t_track_next     = t_track_reg;
        t_sector_next    = t_sector_reg;
        inc_next         = inc_reg;
        time_next        = time_reg;
        cnt_next         = cnt_reg;

        // new request: clamp the head onto a shrunken disk
        if (cmd.load)
        begin
            tgt_next  = target_sector;
            time_next = '0;
            cnt_next  = '0;
            if (NT_W'(head_track_reg) >= nt)
                head_track_next = nt_m1[TRACK_W-1:0];
        end

        // capture division results
        if (div_done)
        begin
            case (cmd.div_sel)
                DIV_SEL_HEAD: head_sector_next = div_rem[SECTOR_W-1:0];
                DIV_SEL_INC:  inc_next         = div_rem[SECTOR_W-1:0];
                DIV_SEL_TGT:
                begin
                    t_track_next  = div_quo;
                    t_sector_next = div_rem[SECTOR_W-1:0];
                end
                default: ;
            endcase
        end

        // one track step, reversing at either edge of the disk
        if (cmd.step)
        begin
            time_next        = time_reg + TIME_W'(step_delay);
            head_sector_next = sec_stepped;
            cnt_next         = cnt_reg + 1'b1;
            if (moving_up_reg)
            begin
                if (at_top)
                begin
                    moving_up_next  = 1'b0;
                    head_track_next = head_track_reg - 1'b1;
                end
                else
                    head_track_next = head_track_reg + 1'b1;
            end
            else
            begin
                if (head_track_reg == '0)
                begin
                    moving_up_next  = 1'b1;
                    head_track_next = head_track_reg + 1'b1;
                end
                else
                    head_track_next = head_track_reg - 1'b1;
            end
        end

        // rotational wait on the target track
        if (cmd.sector_wait)
        begin
            time_next        = time_reg + TIME_W'(wait_prod);
            head_sector_next = t_sector_reg;
        end
    end

    // output register, freed by a transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_id_next    = out_id_reg;
        out_time_next  = out_time_reg;
        out_bad_next   = out_bad_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_id_next    = id_full[SECTOR_ID_W-1:0];
            out_time_next  = bad ? '0 : time_reg;
            out_bad_next   = bad;
            out_last_next  = status.last;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_track_reg  <= '0;
            head_sector_reg <= '0;
            moving_up_reg   <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            head_track_reg  <= head_track_next;
            head_sector_reg <= head_sector_next;
            moving_up_reg   <= moving_up_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tgt_reg      <= tgt_next;
        t_track_reg  <= t_track_next;
        t_sector_reg <= t_sector_next;
        inc_reg      <= inc_next;
        time_reg     <= time_next;
        cnt_reg      <= cnt_next;
        out_id_reg   <= out_id_next;
        out_time_reg <= out_time_next;
        out_bad_reg  <= out_bad_next;
        out_last_reg <= out_last_next;
    end

    // status to the controller
    always_comb
    begin
        status.div_done   = div_done;
        status.bad        = bad;
        status.at_target  = track_hit && sector_hit;
        status.more_steps = more_steps;
        status.last       = bad || (!more_steps && sector_hit);
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign visited_sector = out_id_reg;
    assign elapsed_time   = out_time_reg;
    assign bad_request    = out_bad_reg;
    assign last_of_run    = out_last_reg;
endmodule

/* src/seek_ctrl.sv */
module seek_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  seek_pkg::seek_status_t status,
    output seek_pkg::seek_cmd_t    cmd
);
    import seek_pkg::*;

    seek_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_DIV_HEAD;
            ST_DIV_HEAD:
                state_next = ST_WAIT_HEAD;
            ST_WAIT_HEAD:
                if (status.div_done)
                    state_next = ST_DIV_INC;
            ST_DIV_INC:
                state_next = ST_WAIT_INC;
            ST_WAIT_INC:
                if (status.div_done)
                    state_next = ST_DIV_TGT;
            ST_DIV_TGT:
                state_next = ST_WAIT_TGT;
            ST_WAIT_TGT:
                if (status.div_done)
                    state_next = ST_CHECK;
            ST_CHECK:
                if (status.bad || status.at_target)
                    state_next = ST_EMIT;
                else if (status.more_steps)
                    state_next = ST_STEP;
                else
                    state_next = ST_SECTOR_WAIT;
            ST_STEP:
                state_next = ST_EMIT;
            ST_SECTOR_WAIT:
                state_next = ST_EMIT;
            ST_EMIT:
                if (status.out_free)
                begin
                    if (status.last)
                        state_next = ST_IDLE;
                    else if (status.more_steps)
                        state_next = ST_STEP;
                    else
                        state_next = ST_SECTOR_WAIT;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        in_ready        = 1'b0;
        cmd.load        = 1'b0;
        cmd.div_start   = 1'b0;
        cmd.div_sel     = DIV_SEL_HEAD;
        cmd.step        = 1'b0;
        cmd.sector_wait = 1'b0;
        cmd.emit        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIV_HEAD:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_HEAD;
            end
            ST_WAIT_HEAD:
                cmd.div_sel = DIV_SEL_HEAD;
            ST_DIV_INC:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_INC;
            end
            ST_WAIT_INC:
                cmd.div_sel = DIV_SEL_INC;
            ST_DIV_TGT:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_TGT;
            end
            ST_WAIT_TGT:
                cmd.div_sel = DIV_SEL_TGT;
            ST_STEP:
                cmd.step = 1'b1;
            ST_SECTOR_WAIT:
                cmd.sector_wait = 1'b1;
            ST_EMIT:
                cmd.emit = status.out_free;
            default: ;
        endcase
    end
endmodule

/* src/scan_disk_head_seek_model.sv */
// SCAN disk head seek model. Each request on the input channel is a linear
// sector id; the block walks the head one track per result in its current
// direction, reversing at the first and last track, then waits for the target
// sector, and sends every visited position with the elapsed time (1/256 ms)
// on the output channel, marking the last one. Requests are handled one at a
// time: a request first runs three 11-step remainder divisions on one shared
// restoring divider (head sector, increment and target against the sector
// count; the target division also gives its track as the quotient), then for
// each result the controller updates the head and loads the output register,
// waiting while that register holds a result not yet taken (a flagged or
// already reached target needs only the load), with at most 2 * MAX_TRACKS - 2 results.
// The next request is taken as soon as the last result sits in the output
// register. The user must write configuration over the APB port only while
// no request is in progress; the block itself does not enforce it.
module scan_disk_head_seek_model #(
    parameter int MAX_TRACKS  = seek_pkg::MAX_TRACKS_DEF,
    parameter int MAX_SECTORS = seek_pkg::MAX_SECTORS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [seek_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [seek_pkg::APB_DATA_W-1:0] pwdata,
    output logic [seek_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    seek_in_if.sink                         req,
    seek_out_if.source                      res
);
    import seek_pkg::*;

    localparam int NT_W = $clog2(MAX_TRACKS + 1);
    localparam int NS_W = $clog2(MAX_SECTORS + 1);

    logic [NT_W-1:0]    nt;
    logic [NS_W-1:0]    ns;
    logic [INC_W-1:0]   sector_increment;
    logic [DELAY_W-1:0] step_delay;
    logic [DELAY_W-1:0] sector_delay;
    seek_cmd_t          cmd;
    seek_status_t       status;

    // configuration registers
    seek_regs #(
        .MAX_TRACKS  (MAX_TRACKS),
        .MAX_SECTORS (MAX_SECTORS)
    ) u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .nt               (nt),
        .ns               (ns),
        .sector_increment (sector_increment),
        .step_delay       (step_delay),
        .sector_delay     (sector_delay)
    );

    // sequencer
    seek_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // head, timing and output register
    seek_dp #(
        .MAX_TRACKS  (MAX_TRACKS),
        .MAX_SECTORS (MAX_SECTORS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .target_sector    (req.target_sector),
        .nt               (nt),
        .ns               (ns),
        .sector_increment (sector_increment),
        .step_delay       (step_delay),
        .sector_delay     (sector_delay),
        .out_valid        (res.valid),
        .out_ready        (res.ready),
        .visited_sector   (res.visited_sector),
        .elapsed_time     (res.elapsed_time),
        .bad_request      (res.bad_request),
        .last_of_run      (res.last_of_run)
    );
endmodule
